// ===== design/lesf_pkg.sv =====
// Shared types and constants for the largest empty square finder.
// No dependencies; every other file in design/ refers to this package.

package lesf_pkg;

  localparam int CHAR_W   = 8;
  localparam int DIM_W    = 11;
  localparam int CFG_W    = 11;
  localparam int ROW_W    = 10;
  localparam int COL_W    = 10;
  localparam int SIZE_W   = 11;
  localparam int EPOCH_W  = 8;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  localparam logic [CHAR_W-1:0] EMPTY_CHAR_RST = 8'd46;
  localparam logic [DIM_W-1:0]  GRID_DIM_RST   = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_CHAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS  = 2'd2;

  typedef struct packed {
    logic is_empty;
    logic grid_end;
  } cell_ctl_t;

  typedef struct packed {
    logic clearing;
    logic epoch_full;
  } lb_stat_t;

endpackage

// ===== design/lesf_scan.sv =====
// Front end: grid position counters, request acceptance and the cell register.
// Depends on lesf_pkg.

module lesf_scan #(
  parameter int MAX_ROWS = lesf_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lesf_pkg::MAX_COLS_DEF,
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RW1 = RW + 1,
  localparam int CW1 = CW + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [lesf_pkg::CHAR_W-1:0]  empty_char,
  input  logic [lesf_pkg::DIM_W-1:0]   grid_rows,
  input  logic [lesf_pkg::DIM_W-1:0]   grid_cols,
  input  logic                         in_valid,
  input  logic [lesf_pkg::CHAR_W-1:0]  in_cell_req,
  output logic                         in_stall,
  input  lesf_pkg::lb_stat_t           lb_stat,
  input  logic                         adv,
  output logic                         accept,
  output logic [CW-1:0]                rd_addr,
  output logic                         s1_valid,
  output lesf_pkg::cell_ctl_t          s1_ctl,
  output logic [CW-1:0]                s1_col,
  output logic [RW-1:0]                s1_row
);

  logic [CW-1:0]       col_cnt_r, col_cnt_nxt;
  logic [RW-1:0]       row_cnt_r, row_cnt_nxt;
  logic [CW1-1:0]      cols_eff;
  logic [RW1-1:0]      rows_eff;
  logic                last_col, last_row;
  logic                s1_valid_r, s1_valid_nxt;
  lesf_pkg::cell_ctl_t s1_ctl_r;
  logic [CW-1:0]       s1_col_r;
  logic [RW-1:0]       s1_row_r;

  always_comb begin
    if (grid_cols == '0) begin
      cols_eff = CW1'(1);
    end else if (32'(grid_cols) > MAX_COLS) begin
      cols_eff = CW1'(MAX_COLS);
    end else begin
      cols_eff = CW1'(grid_cols);
    end
    if (grid_rows == '0) begin
      rows_eff = RW1'(1);
    end else if (32'(grid_rows) > MAX_ROWS) begin
      rows_eff = RW1'(MAX_ROWS);
    end else begin
      rows_eff = RW1'(grid_rows);
    end
  end

  assign last_col = (CW1'(col_cnt_r) + CW1'(1)) >= cols_eff;
  assign last_row = (RW1'(row_cnt_r) + RW1'(1)) >= rows_eff;

  assign in_stall = lb_stat.clearing ||
                    (s1_valid_r && (!adv || (s1_ctl_r.grid_end && lb_stat.epoch_full)));
  assign accept   = in_valid && !in_stall;
  assign rd_addr  = col_cnt_r;

  always_comb begin
    col_cnt_nxt  = col_cnt_r;
    row_cnt_nxt  = row_cnt_r;
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
      if (last_col) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = last_row ? '0 : row_cnt_r + RW'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + CW'(1);
      end
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r.is_empty <= (in_cell_req == empty_char);
      s1_ctl_r.grid_end <= last_col && last_row;
      s1_col_r          <= col_cnt_r;
      s1_row_r          <= row_cnt_r;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_ctl   = s1_ctl_r;
  assign s1_col   = s1_col_r;
  assign s1_row   = s1_row_r;

endmodule

// ===== design/lesf_line_buf.sv =====
// Line buffer of running square sizes, tagged with a grid epoch so that a new
// grid reads zeros; sweeps the memory after reset and on epoch wrap. Uses lesf_pkg.

module lesf_line_buf #(
  parameter int MAX_COLS = lesf_pkg::MAX_COLS_DEF,
  parameter int SZ_W     = lesf_pkg::SIZE_W,
  localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int WORD_W  = lesf_pkg::EPOCH_W + SZ_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [CW-1:0]      rd_addr,
  input  logic               wr_en,
  input  logic [CW-1:0]      wr_addr,
  input  logic [SZ_W-1:0]    wr_size,
  input  logic               grid_done,
  output logic [SZ_W-1:0]    up_size,
  output lesf_pkg::lb_stat_t stat
);

  localparam logic [CW-1:0] LAST_ADDR = CW'(MAX_COLS - 1);

  logic [WORD_W-1:0]            mem [MAX_COLS];
  logic [WORD_W-1:0]            rd_word_r;
  logic [WORD_W-1:0]            wr_word;
  logic [lesf_pkg::EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic                         clearing_r, clearing_nxt;
  logic [CW-1:0]                clr_addr_r, clr_addr_nxt;

  assign wr_word = {epoch_r, wr_size};

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_word_r <= wr_word;
      end else begin
        rd_word_r <= mem[rd_addr];
      end
    end
  end

  assign up_size = (rd_word_r[WORD_W-1 -: lesf_pkg::EPOCH_W] == epoch_r) ?
                   rd_word_r[SZ_W-1:0] : '0;

  always_comb begin
    epoch_nxt    = epoch_r;
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      if (clr_addr_r == LAST_ADDR) begin
        clearing_nxt = 1'b0;
        clr_addr_nxt = '0;
      end else begin
        clr_addr_nxt = clr_addr_r + CW'(1);
      end
    end else if (grid_done) begin
      if (epoch_r == '1) begin
        clearing_nxt = 1'b1;
        epoch_nxt    = lesf_pkg::EPOCH_W'(1);
      end else begin
        epoch_nxt = epoch_r + lesf_pkg::EPOCH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r    <= lesf_pkg::EPOCH_W'(1);
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      epoch_r    <= epoch_nxt;
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign stat.clearing   = clearing_r;
  assign stat.epoch_full = (epoch_r == '1);

endmodule

// ===== design/lesf_core.sv =====
// Square size update for one cell, best-square tracking and the result register.
// Depends on lesf_pkg.

module lesf_core #(
  parameter int MAX_ROWS = lesf_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lesf_pkg::MAX_COLS_DEF,
  localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int MAX_DIM = (MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS,
  localparam int SZ_W    = $clog2(MAX_DIM + 1),
  localparam int XW0     = (RW > CW) ? RW : CW,
  localparam int XW      = ((XW0 > SZ_W) ? XW0 : SZ_W) + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s1_valid,
  input  lesf_pkg::cell_ctl_t         s1_ctl,
  input  logic [CW-1:0]               s1_col,
  input  logic [RW-1:0]               s1_row,
  input  logic [SZ_W-1:0]             up_size,
  output logic                        adv,
  output logic [SZ_W-1:0]             cell_size,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [lesf_pkg::ROW_W-1:0]  out_best_row,
  output logic [lesf_pkg::COL_W-1:0]  out_best_col,
  output logic [lesf_pkg::SIZE_W-1:0] out_best_size
);

  logic [SZ_W-1:0] left_r, diag_r;
  logic [SZ_W-1:0] left_sz, diag_sz, min_a, min_b;
  logic [XW-1:0]   size_x, r1_x, c1_x, tr_x, tc_x;
  logic [RW-1:0]   top_row;
  logic [CW-1:0]   top_col;
  logic            better;
  logic [SZ_W-1:0] best_size_r, best_size_nxt;
  logic [RW-1:0]   best_row_r, best_row_nxt;
  logic [CW-1:0]   best_col_r, best_col_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [lesf_pkg::ROW_W-1:0]  out_row_r;
  logic [lesf_pkg::COL_W-1:0]  out_col_r;
  logic [lesf_pkg::SIZE_W-1:0] out_size_r;

  assign adv = s1_valid && (!s1_ctl.grid_end || !out_valid_r || !out_stall);

  always_comb begin
    left_sz = (s1_col == '0) ? '0 : left_r;
    diag_sz = (s1_col == '0) ? '0 : diag_r;
    min_a   = (up_size < left_sz) ? up_size : left_sz;
    min_b   = (min_a < diag_sz) ? min_a : diag_sz;
    r1_x    = XW'(s1_row) + XW'(1);
    c1_x    = XW'(s1_col) + XW'(1);
    size_x  = s1_ctl.is_empty ? (XW'(min_b) + XW'(1)) : '0;
    if (size_x > r1_x) begin
      size_x = r1_x;
    end
    if (size_x > c1_x) begin
      size_x = c1_x;
    end
    tr_x    = r1_x - size_x;
    tc_x    = c1_x - size_x;
  end

  assign cell_size = SZ_W'(size_x);
  assign top_row   = RW'(tr_x);
  assign top_col   = CW'(tc_x);

  assign better = (cell_size != '0) &&
                  ((cell_size > best_size_r) ||
                   ((cell_size == best_size_r) &&
                    ((top_row < best_row_r) ||
                     ((top_row == best_row_r) && (top_col < best_col_r)))));

  always_comb begin
    best_size_nxt = better ? cell_size : best_size_r;
    best_row_nxt  = better ? top_row   : best_row_r;
    best_col_nxt  = better ? top_col   : best_col_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (adv && s1_ctl.grid_end) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_size_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        if (s1_ctl.grid_end) begin
          best_size_r <= '0;
          best_row_r  <= '0;
          best_col_r  <= '0;
        end else begin
          best_size_r <= best_size_nxt;
          best_row_r  <= best_row_nxt;
          best_col_r  <= best_col_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      left_r <= cell_size;
      diag_r <= up_size;
      if (s1_ctl.grid_end) begin
        out_row_r  <= lesf_pkg::ROW_W'(best_row_nxt);
        out_col_r  <= lesf_pkg::COL_W'(best_col_nxt);
        out_size_r <= lesf_pkg::SIZE_W'(best_size_nxt);
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_best_row  = out_row_r;
  assign out_best_col  = out_col_r;
  assign out_best_size = out_size_r;

endmodule

// ===== design/largest_empty_square_finder_unit.sv =====
// Top level of the largest empty square finder: config registers and assembly.
// Depends on lesf_pkg, lesf_scan, lesf_line_buf and lesf_core.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   in       | in_valid / in_stall  | in_cell_req
//   out      | out_valid / out_stall| out_best_row, out_best_col, out_best_size
//   cfg      | cfg_we               | cfg_index, cfg_wdata
//
// One cell per cycle while in_stall is low; a cell waits in the cell register next to the
// line buffer's registered read, and the result is registered as the last cell leaves it.
// After reset the line buffer is swept over all MAX_COLS addresses with in_stall high;
// the same sweep runs again after every 255th grid (the epoch tag wraps).
// out_stall holds only the last cell of a grid while an older result waits.

module largest_empty_square_finder_unit #(
  parameter int MAX_ROWS = lesf_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lesf_pkg::MAX_COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [lesf_pkg::CHAR_W-1:0]    in_cell_req,
  output logic                           in_stall,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lesf_pkg::ROW_W-1:0]     out_best_row,
  output logic [lesf_pkg::COL_W-1:0]     out_best_col,
  output logic [lesf_pkg::SIZE_W-1:0]    out_best_size,
  input  logic                           cfg_we,
  input  logic [lesf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lesf_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int MAX_DIM = (MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int SZ_W    = $clog2(MAX_DIM + 1);

  logic [lesf_pkg::CHAR_W-1:0] empty_char_r;
  logic [lesf_pkg::DIM_W-1:0]  grid_rows_r;
  logic [lesf_pkg::DIM_W-1:0]  grid_cols_r;

  lesf_pkg::lb_stat_t  lb_stat;
  lesf_pkg::cell_ctl_t s1_ctl;
  logic                accept, adv, s1_valid;
  logic [CW-1:0]       rd_addr, s1_col;
  logic [RW-1:0]       s1_row;
  logic [SZ_W-1:0]     up_size, cell_size;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_char_r <= lesf_pkg::EMPTY_CHAR_RST;
      grid_rows_r  <= lesf_pkg::GRID_DIM_RST;
      grid_cols_r  <= lesf_pkg::GRID_DIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lesf_pkg::CFG_EMPTY_CHAR: empty_char_r <= cfg_wdata[lesf_pkg::CHAR_W-1:0];
        lesf_pkg::CFG_GRID_ROWS:  grid_rows_r  <= cfg_wdata[lesf_pkg::DIM_W-1:0];
        lesf_pkg::CFG_GRID_COLS:  grid_cols_r  <= cfg_wdata[lesf_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  lesf_scan #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty_char  (empty_char_r),
    .grid_rows   (grid_rows_r),
    .grid_cols   (grid_cols_r),
    .in_valid    (in_valid),
    .in_cell_req (in_cell_req),
    .in_stall    (in_stall),
    .lb_stat     (lb_stat),
    .adv         (adv),
    .accept      (accept),
    .rd_addr     (rd_addr),
    .s1_valid    (s1_valid),
    .s1_ctl      (s1_ctl),
    .s1_col      (s1_col),
    .s1_row      (s1_row)
  );

  lesf_line_buf #(
    .MAX_COLS (MAX_COLS),
    .SZ_W     (SZ_W)
  ) u_line_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_addr   (rd_addr),
    .wr_en     (adv),
    .wr_addr   (s1_col),
    .wr_size   (cell_size),
    .grid_done (adv && s1_ctl.grid_end),
    .up_size   (up_size),
    .stat      (lb_stat)
  );

  lesf_core #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .s1_valid      (s1_valid),
    .s1_ctl        (s1_ctl),
    .s1_col        (s1_col),
    .s1_row        (s1_row),
    .up_size       (up_size),
    .adv           (adv),
    .cell_size     (cell_size),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_best_row  (out_best_row),
    .out_best_col  (out_best_col),
    .out_best_size (out_best_size)
  );

  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) lb_stat.clearing |-> !accept
  ) else $error("request accepted during line buffer sweep");

  a_result_from_grid_end: assert property (
    @(posedge clk) disable iff (!rst_n)
      (!out_valid || !out_stall) ##1 out_valid |-> $past(adv && s1_ctl.grid_end)
  ) else $error("result loaded without a grid end");

  a_grid_restarts_at_origin: assert property (
    @(posedge clk) disable iff (!rst_n)
      (adv && s1_ctl.grid_end && accept) |=> (s1_col == '0) && (s1_row == '0)
  ) else $error("cell after grid end not at origin");

  a_size_bounded: assert property (
    @(posedge clk) disable iff (!rst_n)
      s1_valid |-> (cell_size <= SZ_W'(MAX_DIM))
  ) else $error("square size exceeds grid bound");

endmodule
